FILE: rtl/core/hbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, character constants and header match patterns for the body deframer.
// No dependencies; used by the scanner, framing FSM and top level.
package hbd_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;

  localparam int POS_W = 5;
  typedef logic [POS_W-1:0] match_pos_t;

  localparam int CHUNK_PAT_LEN = 28;
  localparam int LEN_PAT_LEN   = 18;

  localparam match_pos_t CHUNK_PAT_END = match_pos_t'(CHUNK_PAT_LEN);
  localparam match_pos_t LEN_PAT_END   = match_pos_t'(LEN_PAT_LEN);

  localparam logic [8*CHUNK_PAT_LEN-1:0] CHUNK_PAT = {CH_CR, CH_LF, "Transfer-Encoding: chunked"};
  localparam logic [8*LEN_PAT_LEN-1:0]   LEN_PAT   = {CH_CR, CH_LF, "Content-Length: "};

  // matcher outputs for one byte
  typedef struct packed {
    match_pos_t  chunk_pos;
    logic        chunk_hit;
    match_pos_t  len_pos;
    logic        len_hit;
    logic [1:0]  blank_pos;
    logic        blank_hit;
  } hbd_scan_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_valid;
    logic       message_done;
    logic       length_error;
  } hbd_result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // caller keeps p below the pattern length
  function automatic logic [7:0] chunk_pat_char(input match_pos_t p);
    return CHUNK_PAT[8*(CHUNK_PAT_LEN-1-int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] len_pat_char(input match_pos_t p);
    return LEN_PAT[8*(LEN_PAT_LEN-1-int'(p)) +: 8];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hbd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready stream interfaces for raw response bytes and deframed results.
// Does not depend on hbd_pkg.
interface hbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       segment_end;

  modport source (output valid, output data_byte, output segment_end, input ready);
  modport sink   (input valid, input data_byte, input segment_end, output ready);
endinterface

interface hbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       body_valid;
  logic       message_done;
  logic       length_error;

  modport source (output valid, output body_byte, output body_valid,
                  output message_done, output length_error, input ready);
  modport sink   (input valid, input body_byte, input body_valid,
                  input message_done, input length_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hbd_hdr_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// Case-insensitive header line matchers: chunked encoding, content length, blank line.
// Depends on hbd_pkg.
module hbd_hdr_scan import hbd_pkg::*; (
  input  logic [7:0] byte_i,
  input  match_pos_t chunk_pos_i,
  input  match_pos_t len_pos_i,
  input  logic [1:0] blank_pos_i,
  output hbd_scan_t  scan_o
);

  logic [7:0] c_fold;
  logic       is_cr;
  match_pos_t chunk_p, chunk_n;
  match_pos_t len_p, len_n;
  logic [2:0] blank_n;
  logic [7:0] blank_ch;

  assign c_fold = fold_case(byte_i);
  assign is_cr  = (byte_i == CH_CR);

  // positions past the end restart the match
  assign chunk_p = (chunk_pos_i >= CHUNK_PAT_END) ? '0 : chunk_pos_i;
  assign len_p   = (len_pos_i >= LEN_PAT_END) ? '0 : len_pos_i;

  assign chunk_n = (c_fold == fold_case(chunk_pat_char(chunk_p))) ? chunk_p + 1'b1
                 : (is_cr ? match_pos_t'(1) : '0);
  assign len_n   = (c_fold == fold_case(len_pat_char(len_p))) ? len_p + 1'b1
                 : (is_cr ? match_pos_t'(1) : '0);

  assign blank_ch = blank_pos_i[0] ? CH_LF : CH_CR;
  assign blank_n  = (byte_i == blank_ch) ? {1'b0, blank_pos_i} + 3'd1
                  : (is_cr ? 3'd1 : 3'd0);

  always_comb begin
    scan_o.chunk_hit = (chunk_n == CHUNK_PAT_END);
    scan_o.chunk_pos = scan_o.chunk_hit ? '0 : chunk_n;
    scan_o.len_hit   = (len_n == LEN_PAT_END);
    scan_o.len_pos   = scan_o.len_hit ? '0 : len_n;
    scan_o.blank_hit = blank_n[2];
    scan_o.blank_pos = blank_n[2] ? 2'd0 : blank_n[1:0];
  end

endmodule
`default_nettype wire

FILE: rtl/core/hbd_frame_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// Framing state machine: header scan, length/chunk size parsing, body byte gating.
// Depends on hbd_pkg and hbd_hdr_scan.
module hbd_frame_fsm import hbd_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output hbd_result_t res_o
);

  localparam int ACC_W = LENGTH_BITS + 4;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_LEN_SPACE = 4'd1,
    PH_LEN_DIGIT = 4'd2,
    PH_BODY      = 4'd3,
    PH_SIZE      = 4'd4,
    PH_DATA      = 4'd5,
    PH_TRAIL_A   = 4'd6,
    PH_TRAIL_B   = 4'd7
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             blank_pos_r, blank_pos_nxt;
  match_pos_t             chunk_pos_r, chunk_pos_nxt;
  match_pos_t             len_pos_r, len_pos_nxt;
  logic                   chunked_r, chunked_nxt;
  logic                   has_len_r, has_len_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] br_r, br_nxt;
  logic                   sde_r, sde_nxt;

  hbd_scan_t              scan;
  logic [ACC_W-1:0]       dec_sum;
  logic                   dec_ovf, hex_ovf, is_dec;
  logic [LENGTH_BITS-1:0] dec_val, hex_val, br_dec;
  logic [4:0]             hex;

  phase_t                 hdr_ph;
  logic [LENGTH_BITS-1:0] hdr_acc;
  logic                   hdr_err, hdr_has;
  logic                   valid_c, done_c, err_c, go_hdr;

  hbd_hdr_scan u_scan (
    .byte_i      (byte_i),
    .chunk_pos_i (chunk_pos_r),
    .len_pos_i   (len_pos_r),
    .blank_pos_i (blank_pos_r),
    .scan_o      (scan)
  );

  // acc*10 + digit as shift-add; anything above LENGTH_BITS is overflow
  assign is_dec  = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign dec_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + ACC_W'(byte_i[3:0]);
  assign dec_ovf = |dec_sum[ACC_W-1:LENGTH_BITS];
  assign dec_val = dec_ovf ? '1 : dec_sum[LENGTH_BITS-1:0];

  assign hex     = hex_digit(byte_i);
  assign hex_ovf = |acc_r[LENGTH_BITS-1:LENGTH_BITS-4];
  assign hex_val = hex_ovf ? '1 : {acc_r[LENGTH_BITS-5:0], hex[3:0]};

  assign br_dec  = (br_r != '0) ? br_r - 1'b1 : '0;

  always_comb begin
    // header-phase length field handling
    hdr_ph  = (phase_r == PH_LEN_SPACE || phase_r == PH_LEN_DIGIT) ? phase_r : PH_HEADER;
    hdr_acc = acc_r;
    hdr_err = 1'b0;
    hdr_has = has_len_r;
    if (hdr_ph != PH_HEADER) begin
      if (is_dec) begin
        hdr_acc = dec_val;
        hdr_err = dec_ovf;
        hdr_ph  = PH_LEN_DIGIT;
      end else if (!(byte_i == CH_SP && hdr_ph == PH_LEN_SPACE)) begin
        hdr_ph = PH_HEADER;
      end
    end
    // only the first Content-Length of a header counts
    if (scan.len_hit && !has_len_r) begin
      hdr_has = 1'b1;
      hdr_acc = '0;
      hdr_ph  = PH_LEN_SPACE;
    end

    phase_nxt     = phase_r;
    blank_pos_nxt = blank_pos_r;
    chunk_pos_nxt = chunk_pos_r;
    len_pos_nxt   = len_pos_r;
    chunked_nxt   = chunked_r;
    has_len_nxt   = has_len_r;
    acc_nxt       = acc_r;
    br_nxt        = br_r;
    sde_nxt       = sde_r;
    valid_c       = 1'b0;
    done_c        = 1'b0;
    err_c         = 1'b0;
    go_hdr        = 1'b0;

    unique case (phase_r)
      PH_BODY: begin
        valid_c = 1'b1;
        br_nxt  = br_dec;
        if (br_dec == '0) begin
          done_c = 1'b1;
          go_hdr = 1'b1;
        end
      end
      PH_SIZE: begin
        if (byte_i == CH_LF) begin
          if (acc_r == '0) begin
            done_c = 1'b1;
            go_hdr = 1'b1;
          end else begin
            br_nxt    = acc_r;
            phase_nxt = PH_DATA;
          end
        end else if (!sde_r && hex[4]) begin
          acc_nxt = hex_val;
          err_c   = hex_ovf;
        end else begin
          sde_nxt = 1'b1;
        end
      end
      PH_DATA: begin
        valid_c = 1'b1;
        br_nxt  = br_dec;
        if (br_dec == '0) begin
          phase_nxt = PH_TRAIL_A;
        end
      end
      PH_TRAIL_A: begin
        phase_nxt = PH_TRAIL_B;
      end
      PH_TRAIL_B: begin
        phase_nxt = PH_SIZE;
        acc_nxt   = '0;
        sde_nxt   = 1'b0;
      end
      default: begin
        // header, length field, or an unused code (treated as header)
        phase_nxt     = hdr_ph;
        acc_nxt       = hdr_acc;
        err_c         = hdr_err;
        has_len_nxt   = hdr_has;
        chunked_nxt   = chunked_r | scan.chunk_hit;
        chunk_pos_nxt = scan.chunk_pos;
        len_pos_nxt   = scan.len_pos;
        blank_pos_nxt = scan.blank_pos;
        if (scan.blank_hit) begin
          chunk_pos_nxt = '0;
          len_pos_nxt   = '0;
          blank_pos_nxt = '0;
          if (chunked_nxt) begin
            phase_nxt = PH_SIZE;
            acc_nxt   = '0;
            sde_nxt   = 1'b0;
          end else if (hdr_has && hdr_acc != '0) begin
            phase_nxt = PH_BODY;
            br_nxt    = hdr_acc;
          end else begin
            done_c = 1'b1;
            go_hdr = 1'b1;
          end
        end
      end
    endcase

    if (go_hdr) begin
      phase_nxt     = PH_HEADER;
      blank_pos_nxt = '0;
      chunk_pos_nxt = '0;
      len_pos_nxt   = '0;
      chunked_nxt   = 1'b0;
      has_len_nxt   = 1'b0;
      acc_nxt       = '0;
      br_nxt        = '0;
      sde_nxt       = 1'b0;
    end
  end

  always_comb begin
    res_o.body_byte    = valid_c ? byte_i : 8'h00;
    res_o.body_valid   = valid_c;
    res_o.message_done = done_c;
    res_o.length_error = err_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      blank_pos_r <= '0;
      chunk_pos_r <= '0;
      len_pos_r   <= '0;
      chunked_r   <= 1'b0;
      has_len_r   <= 1'b0;
      acc_r       <= '0;
      br_r        <= '0;
      sde_r       <= 1'b0;
    end else if (step_i) begin
      phase_r     <= phase_nxt;
      blank_pos_r <= blank_pos_nxt;
      chunk_pos_r <= chunk_pos_nxt;
      len_pos_r   <= len_pos_nxt;
      chunked_r   <= chunked_nxt;
      has_len_r   <= has_len_nxt;
      acc_r       <= acc_nxt;
      br_r        <= br_nxt;
      sde_r       <= sde_nxt;
    end
  end

  // body and chunk data phases are only entered with a nonzero count
  a_body_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> br_r != '0)
    else $error("body phase with zero remaining count");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> br_r != '0)
    else $error("chunk data phase with zero remaining count");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && done_c |=> phase_r == PH_HEADER && !chunked_r && !has_len_r && acc_r == '0)
    else $error("message end did not return to a clean header state");

  a_trailer_seq: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && phase_r == PH_TRAIL_A |=> phase_r == PH_TRAIL_B)
    else $error("chunk trailer sequence broken");

endmodule
`default_nettype wire

FILE: rtl/core/http_body_deframer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// HTTP response body deframer, top level.
// Depends on hbd_pkg, hbd_if and hbd_frame_fsm.
//
// in_chan carries the raw response stream, one byte per transfer (segment_end is
// accepted but framing ignores it). out_chan returns exactly one result per
// input byte: the byte itself when it belongs to the body (zero otherwise), a
// body flag, a message-done flag and a length overflow flag.
// Headers are scanned to the blank line; Content-Length or chunked framing then
// selects which following bytes are body. Lengths are LENGTH_BITS wide.
//
// Throughput: one byte per cycle while out_chan keeps taking results. A byte
// taken from in_chan passes through an input register, the framing update
// logic, and an output register; framing state advances when the input
// register hands its byte to the output register.
// Reset (rst_n low, synchronous) empties both registers and puts the parser back
// in header phase. When out_chan stalls, the output register holds its result and
// the input register holds one more byte; in_chan.ready drops only when both are
// full and the output is not being taken.
module http_body_deframer_core import hbd_pkg::*; #(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  hbd_in_if.sink           in_chan,
  hbd_out_if.source        out_chan
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  hbd_result_t out_res_r;
  hbd_result_t step_res;
  logic        step;

  // input register moves into the output register when that one is free or draining
  assign step          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || step;

  hbd_frame_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (s1_byte_r),
    .res_o  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
    end
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.body_byte    = out_res_r.body_byte;
  assign out_chan.body_valid   = out_res_r.body_valid;
  assign out_chan.message_done = out_res_r.message_done;
  assign out_chan.length_error = out_res_r.length_error;

  // a held input byte stays put until the framing logic consumes it
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost or changed a pending byte");

  // a result is never overwritten while still waiting on the output
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !step)
    else $error("output register overwritten under stall");

  // a body byte never coincides with a length overflow
  a_err_not_body: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(step_res.body_valid && step_res.length_error))
    else $error("length error raised on a body byte");

endmodule
`default_nettype wire
